@@ design/mchet_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the hysteresis event table
package mchet_pkg;

    // transaction kinds
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_CHECK   = 3'd1;
    localparam logic [2:0] KIND_INIT    = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_CURRENT = 3'd4;

    // slot states
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_NEAR    = 2'd1;
    localparam logic [1:0] ST_FAR     = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  sensor;
        logic [1:0]  slot;
        logic [7:0]  range;
        logic        connected;
        logic [7:0]  near_level;
        logic [7:0]  far_level;
        logic [15:0] near_event;
        logic [15:0] far_event;
        logic [1:0]  written_state;
        logic [15:0] event_query;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic        event_valid;
        logic [15:0] event_number;
        logic [1:0]  found_state;
    } out_item_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [7:0]  near_level;
        logic [7:0]  far_level;
        logic [15:0] near_event;
        logic [15:0] far_event;
        logic [1:0]  state;
    } entry_t;

    typedef enum logic [1:0] {
        ADDR_ITEM,
        ADDR_BASE,
        ADDR_ZERO,
        ADDR_INC
    } addr_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ITEM,
        WR_STATE
    } wr_op_t;

    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        addr_op_t addr_op;
        wr_op_t   wr_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       in_table;
        logic       sensor_ok;
        logic       match;
        logic       init_last;
        logic       scan_last;
    } dp_status_t;

endpackage

@@ design/mchet_datapath.sv @@
`timescale 1ns / 1ps
// datapath: transaction register, threshold table memory and result logic
module mchet_datapath import mchet_pkg::*; #(
    parameter int SENSOR_COUNT = 4,
    parameter int SLOT_COUNT   = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  res
);

    localparam int TABLE_SIZE = SENSOR_COUNT * SLOT_COUNT;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    in_item_t                item_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic [IDX_W-1:0]        addr_next;
    entry_t                  rd_entry_reg;
    logic [TABLE_SIZE-1:0]   valid_reg;
    entry_t                  table_mem [TABLE_SIZE];

    logic [IDX_W-1:0]        item_idx;
    logic [IDX_W-1:0]        base_idx;
    logic                    in_table;
    logic                    sensor_ok;
    logic                    match;
    logic                    move_near;
    logic                    move_far;
    logic [1:0]              new_state;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    entry_t                  wr_entry;

    // address decode of the held transaction
    assign sensor_ok = 32'(item_reg.sensor) < SENSOR_COUNT;
    assign in_table  = sensor_ok && (32'(item_reg.slot) < SLOT_COUNT);
    assign base_idx  = IDX_W'(32'(item_reg.sensor) * SLOT_COUNT);
    assign item_idx  = IDX_W'(32'(item_reg.sensor) * SLOT_COUNT + 32'(item_reg.slot));

    // hysteresis moves on the entry just read
    assign move_near = (rd_entry_reg.state == ST_FAR)
                       && (item_reg.range < rd_entry_reg.near_level);
    assign move_far  = (rd_entry_reg.state == ST_NEAR)
                       && (item_reg.range > rd_entry_reg.far_level);
    assign match     = (rd_entry_reg.near_event == item_reg.event_query)
                       || (rd_entry_reg.far_event == item_reg.event_query);

    // status back to the controller
    assign status.kind      = item_reg.kind;
    assign status.in_table  = in_table;
    assign status.sensor_ok = sensor_ok;
    assign status.match     = match;
    assign status.init_last = addr_reg == IDX_W'(32'(base_idx) + SLOT_COUNT - 1);
    assign status.scan_last = addr_reg == IDX_W'(TABLE_SIZE - 1);

    // read address select
    always_comb begin
        unique case (cmd.addr_op)
            ADDR_ITEM: addr_next = item_idx;
            ADDR_BASE: addr_next = base_idx;
            ADDR_ZERO: addr_next = '0;
            ADDR_INC:  addr_next = addr_reg + 1'b1;
            default:   addr_next = addr_reg;
        endcase
    end

    // next slot state for write-back
    always_comb begin
        new_state = rd_entry_reg.state;
        if (item_reg.kind == KIND_INIT) begin
            if (!item_reg.connected) begin
                new_state = ST_UNKNOWN;
            end else if (item_reg.range < rd_entry_reg.near_level) begin
                new_state = ST_NEAR;
            end else begin
                new_state = ST_FAR;
            end
        end else if (move_near) begin
            new_state = ST_NEAR;
        end else if (move_far) begin
            new_state = ST_FAR;
        end
    end

    // write port
    always_comb begin
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_entry       = rd_entry_reg;
        wr_entry.state = new_state;
        unique case (cmd.wr_op)
            WR_ITEM: begin
                wr_en               = 1'b1;
                wr_addr             = item_idx;
                wr_entry.near_level = item_reg.near_level;
                wr_entry.far_level  = item_reg.far_level;
                wr_entry.near_event = item_reg.near_event;
                wr_entry.far_event  = item_reg.far_event;
                wr_entry.state      = (item_reg.written_state == ST_NEAR
                                       || item_reg.written_state == ST_FAR)
                                      ? item_reg.written_state : ST_UNKNOWN;
            end
            WR_STATE: wr_en = 1'b1;
            default: wr_en = 1'b0;
        endcase
    end

    // transaction register, table memory and registered read
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
        if (cmd.rd_en) begin
            addr_reg     <= addr_next;
            rd_entry_reg <= valid_reg[addr_next] ? table_mem[addr_next] : '0;
        end
        if (wr_en) begin
            table_mem[wr_addr] <= wr_entry;
        end
    end

    // per-entry written flags, unwritten entries read as reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // result fields
    always_comb begin
        res = '0;
        case (item_reg.kind)
            KIND_WRITE: res.accepted = in_table;
            KIND_CHECK: begin
                res.accepted = in_table;
                if (in_table && move_near) begin
                    res.event_valid  = 1'b1;
                    res.event_number = rd_entry_reg.near_event;
                end else if (in_table && move_far) begin
                    res.event_valid  = 1'b1;
                    res.event_number = rd_entry_reg.far_event;
                end
            end
            KIND_INIT: res.accepted = sensor_ok;
            KIND_QUERY: begin
                res.accepted = 1'b1;
                if (match) begin
                    res.found_state = rd_entry_reg.state;
                end
            end
            KIND_CURRENT: begin
                res.accepted = in_table;
                if (in_table && rd_entry_reg.state == ST_NEAR) begin
                    res.event_valid  = 1'b1;
                    res.event_number = rd_entry_reg.near_event;
                end else if (in_table && rd_entry_reg.state == ST_FAR) begin
                    res.event_valid  = 1'b1;
                    res.event_number = rd_entry_reg.far_event;
                end
            end
            default: res = '0;
        endcase
    end

endmodule

@@ design/mchet_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine sequencing table reads, writes and scans
module mchet_ctrl import mchet_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       res_valid,
    input  logic       out_free
);

    typedef enum logic [2:0] {
        IDLE,
        DISPATCH,
        CHK_EVAL,
        INIT_WR,
        SCAN,
        DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    assign s_ready   = s_ready_reg;
    assign res_valid = state_reg == DONE;

    // next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.addr_op   = ADDR_INC;
        cmd.wr_op     = WR_NONE;
        unique case (state_reg)
            IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load_item = 1'b1;
                    state_next    = DISPATCH;
                end
            end
            DISPATCH: begin
                state_next = DONE;
                unique case (status.kind)
                    KIND_WRITE: begin
                        if (status.in_table) begin
                            cmd.wr_op = WR_ITEM;
                        end
                    end
                    KIND_CHECK: begin
                        if (status.in_table) begin
                            cmd.rd_en   = 1'b1;
                            cmd.addr_op = ADDR_ITEM;
                            state_next  = CHK_EVAL;
                        end
                    end
                    KIND_INIT: begin
                        if (status.sensor_ok) begin
                            cmd.rd_en   = 1'b1;
                            cmd.addr_op = ADDR_BASE;
                            state_next  = INIT_WR;
                        end
                    end
                    KIND_QUERY: begin
                        cmd.rd_en   = 1'b1;
                        cmd.addr_op = ADDR_ZERO;
                        state_next  = SCAN;
                    end
                    KIND_CURRENT: begin
                        if (status.in_table) begin
                            cmd.rd_en   = 1'b1;
                            cmd.addr_op = ADDR_ITEM;
                        end
                    end
                    default: state_next = DONE;
                endcase
            end
            CHK_EVAL: begin
                cmd.wr_op  = WR_STATE;
                state_next = DONE;
            end
            // write back one slot while reading the next
            INIT_WR: begin
                cmd.wr_op = WR_STATE;
                if (status.init_last) begin
                    state_next = DONE;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            // compare one entry per cycle, next read issued alongside
            SCAN: begin
                if (status.match || status.scan_last) begin
                    state_next = DONE;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            DONE: begin
                if (out_free) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= state_next == IDLE;
        end
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == DISPATCH)
        else $error("accepted transaction not dispatched");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == IDLE)
        else $error("ready while busy");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == IDLE |-> cmd.wr_op == WR_NONE && !cmd.rd_en)
        else $error("table access while idle");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SCAN && status.scan_last |-> !cmd.rd_en)
        else $error("scan read past last entry");

endmodule

@@ design/multi_channel_hysteresis_event_table.sv @@
`timescale 1ns / 1ps
// Hysteresis event table: per sensor and slot near/far thresholds with event numbers.
//
// Input channel s_valid/s_ready/s_item carries one transaction: a slot write, a range
// check, a sensor initialise, a search by event number or a current-event report.
// Every transaction gives exactly one result on m_valid/m_ready/m_item.
// One transaction is worked at a time; s_ready is high only while the controller idles.
// The initialise reads the SLOT_COUNT entries of its sensor; the search by event reads up
// to SENSOR_COUNT * SLOT_COUNT entries. The table memory has one read and one write port:
// one entry is read per cycle, with the search scanning entries in order until the first
// match, and a write-back can go alongside a read.
// s_ready rises again at the edge that loads the result, so the next transaction
// can be taken in the following cycle.
// The result register lets the next transaction be accepted while a result waits;
// if the receiver stalls, a finished result holds in the controller until the
// register frees, and no new transaction is taken meanwhile.
// Reset (aresetn low, synchronous) returns to idle, empties the result register and
// clears the per-entry written flags, so every slot reads as zero levels and events
// with state unknown; no clearing pass is needed.
module multi_channel_hysteresis_event_table import mchet_pkg::*; #(
    parameter int SENSOR_COUNT = 4,
    parameter int SLOT_COUNT   = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  res;
    logic       res_valid;
    logic       out_free;
    logic       res_load;
    logic       m_valid_reg;
    out_item_t  m_item_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign res_load = res_valid && out_free;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    mchet_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd),
        .res_valid (res_valid),
        .out_free  (out_free)
    );

    mchet_datapath #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SLOT_COUNT   (SLOT_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .res     (res)
    );

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_item_reg <= res;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted back to back");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !out_free |=> res_valid)
        else $error("finished result dropped while receiver stalled");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> m_valid)
        else $error("loaded result not presented");

endmodule
